[src/ffba_pkg.sv]
package ffba_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ENT_W = 64;

  // Configuration port
  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_HEAP_BASE = 2'd0;
  localparam logic [1:0] REG_HEAP_LIMIT = 2'd1;
  localparam logic [1:0] REG_HEADER_BYTES = 2'd2;

  localparam logic [31:0] HEAP_BASE_RST = 32'd4096;
  localparam logic [31:0] HEAP_LIMIT_RST = 32'd65536;
  localparam logic [7:0] HEADER_BYTES_RST = 8'd32;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_ZERO = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_FULL = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  typedef struct packed {
    logic        func;
    logic [15:0] elem_size;
    logic [15:0] elem_count;
    logic [31:0] release_addr;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] data_addr;
  } out_word_t;

  // Microprogram steps
  typedef enum logic [4:0] {
    S_WAIT,
    S_MUL,
    S_ZCHK,
    S_ASCAN,
    S_ADEC,
    S_FCHK,
    S_ECHK,
    S_NEW,
    S_REUSE,
    S_ZERO,
    S_FULL,
    S_EXH,
    S_RNULL,
    S_RSCAN,
    S_RDEC,
    S_RFREE,
    S_UNK,
    S_ROK
  } ustep_t;

  // Datapath actions
  typedef enum logic [3:0] {
    A_NONE,
    A_TAKE,
    A_MUL,
    A_SCAN,
    A_RES_ZERO,
    A_RES_FULL,
    A_RES_EXH,
    A_RES_UNK,
    A_RES_OK,
    A_REUSE,
    A_NEW,
    A_RFREE
  } action_t;

  // Branch conditions
  typedef enum logic [3:0] {
    C_IN_IDLE,
    C_RELEASE,
    C_REQ_ZERO,
    C_ACONT,
    C_AHIT,
    C_FULL,
    C_EXHAUST,
    C_ADDR_NULL,
    C_RCONT,
    C_RHIT,
    C_OUT_BUSY
  } cond_t;

  // One control word: action, branch condition, target when true, next when false
  typedef struct packed {
    action_t act;
    cond_t   cond;
    ustep_t  jt;
    ustep_t  nx;
  } ucode_t;

  // Control store
  function automatic ucode_t ucode_rom(input ustep_t s);
    ucode_t w;
    case (s)
      S_WAIT:  w = '{A_TAKE,     C_IN_IDLE,   S_WAIT,  S_MUL};
      S_MUL:   w = '{A_MUL,      C_RELEASE,   S_RNULL, S_ZCHK};
      S_ZCHK:  w = '{A_NONE,     C_REQ_ZERO,  S_ZERO,  S_ASCAN};
      S_ASCAN: w = '{A_SCAN,     C_ACONT,     S_ASCAN, S_ADEC};
      S_ADEC:  w = '{A_NONE,     C_AHIT,      S_REUSE, S_FCHK};
      S_FCHK:  w = '{A_NONE,     C_FULL,      S_FULL,  S_ECHK};
      S_ECHK:  w = '{A_NONE,     C_EXHAUST,   S_EXH,   S_NEW};
      S_NEW:   w = '{A_NEW,      C_OUT_BUSY,  S_NEW,   S_WAIT};
      S_REUSE: w = '{A_REUSE,    C_OUT_BUSY,  S_REUSE, S_WAIT};
      S_ZERO:  w = '{A_RES_ZERO, C_OUT_BUSY,  S_ZERO,  S_WAIT};
      S_FULL:  w = '{A_RES_FULL, C_OUT_BUSY,  S_FULL,  S_WAIT};
      S_EXH:   w = '{A_RES_EXH,  C_OUT_BUSY,  S_EXH,   S_WAIT};
      S_RNULL: w = '{A_NONE,     C_ADDR_NULL, S_ROK,   S_RSCAN};
      S_RSCAN: w = '{A_SCAN,     C_RCONT,     S_RSCAN, S_RDEC};
      S_RDEC:  w = '{A_NONE,     C_RHIT,      S_RFREE, S_UNK};
      S_RFREE: w = '{A_RFREE,    C_OUT_BUSY,  S_RFREE, S_WAIT};
      S_UNK:   w = '{A_RES_UNK,  C_OUT_BUSY,  S_UNK,   S_WAIT};
      S_ROK:   w = '{A_RES_OK,   C_OUT_BUSY,  S_ROK,   S_WAIT};
      default: w = '{A_NONE,     C_IN_IDLE,   S_WAIT,  S_WAIT};
    endcase
    return w;
  endfunction

endpackage

[src/ffba_ram.sv]
module ffba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/first_fit_block_allocator.sv]
// A word is taken in the wait step and its size is multiplied out. An allocation then checks
// for a zero size, scans the table for a free block that fits, and checks for a full table
// and an exhausted heap before it carves a new block; a release checks for a null address
// and scans the table for a matching entry. The result is registered, and a stalled output
// holds the result step. One word at a time: the next word is accepted in the wait step.
// Reset (synchronous, rst_n low): empty table, registers at their defaults, heap top at base.
module first_fit_block_allocator (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  ffba_pkg::in_word_t       in_word,
  output logic                     out_valid,
  input  logic                     out_stall,
  output ffba_pkg::out_word_t      out_word,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ffba_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  import ffba_pkg::*;

  // Sequencer
  ustep_t upc_r, upc_nxt;
  ucode_t uw;
  logic   cond_true;

  // Configuration registers
  logic [31:0] heap_base_r, heap_base_nxt;
  logic [31:0] heap_limit_r, heap_limit_nxt;
  logic [7:0]  hdr_r, hdr_nxt;

  // Datapath state
  in_word_t              in_r, in_nxt;
  logic [31:0]           req_r, req_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [31:0]           heap_top_r, heap_top_nxt;
  logic [TABLE_ENTRIES-1:0] in_use_r, in_use_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_r, out_nxt;

  // Table RAM ports
  logic             ram_we;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] ram_rdata;
  logic [31:0]      ent_addr;
  logic [31:0]      ent_size;

  // Decision signals
  logic        ent_valid;
  logic        fit;
  logic        match;
  logic [32:0] new_top;
  logic [31:0] data_base;
  logic        out_busy;
  logic        cfg_wr;

  assign uw = ucode_rom(upc_r);
  assign ent_addr = ram_rdata[63:32];
  assign ent_size = ram_rdata[31:0];
  assign ent_valid = idx_r < count_r;
  assign fit = ent_valid && !in_use_r[idx_r[IDX_W-1:0]] && (ent_size >= req_r);
  assign match = ent_valid && (ent_addr == in_r.release_addr);
  assign new_top = {1'b0, heap_top_r} + {25'd0, hdr_r} + {1'b0, req_r};
  assign data_base = heap_top_r + {24'd0, hdr_r};
  assign out_busy = out_valid_r && out_stall;
  assign cfg_wr = psel && penable && pwrite;

  assign in_stall = (upc_r != S_WAIT);
  assign out_valid = out_valid_r;
  assign out_word = out_r;
  assign pready = 1'b1;

  // Branch condition of the current control word
  always_comb begin
    case (uw.cond)
      C_IN_IDLE:   cond_true = !in_valid;
      C_RELEASE:   cond_true = (in_r.func == FUNC_RELEASE);
      C_REQ_ZERO:  cond_true = (req_r == 32'd0);
      C_ACONT:     cond_true = ent_valid && !fit;
      C_AHIT:      cond_true = fit;
      C_FULL:      cond_true = (count_r == CNT_W'(TABLE_ENTRIES));
      C_EXHAUST:   cond_true = (new_top > {1'b0, heap_limit_r});
      C_ADDR_NULL: cond_true = (in_r.release_addr == 32'd0);
      C_RCONT:     cond_true = ent_valid && !match;
      C_RHIT:      cond_true = match;
      C_OUT_BUSY:  cond_true = out_busy;
      default:     cond_true = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    upc_nxt = cond_true ? uw.jt : uw.nx;
  end

  // Datapath driven by the control word
  always_comb begin
    in_nxt = in_r;
    req_nxt = req_r;
    idx_nxt = idx_r;
    count_nxt = count_r;
    heap_top_nxt = heap_top_r;
    in_use_nxt = in_use_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we = 1'b0;
    ram_wdata = {data_base, req_r};
    heap_base_nxt = heap_base_r;
    heap_limit_nxt = heap_limit_r;
    hdr_nxt = hdr_r;

    case (uw.act)
      A_TAKE: begin
        if (in_valid) begin
          in_nxt = in_word;
        end
      end
      A_MUL: begin
        req_nxt = {16'd0, in_r.elem_size} * {16'd0, in_r.elem_count};
        idx_nxt = '0;
      end
      A_SCAN: begin
        if (cond_true) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      A_NEW: begin
        if (!out_busy) begin
          ram_we = 1'b1;
          in_use_nxt[count_r[IDX_W-1:0]] = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          heap_top_nxt = new_top[31:0];
          out_nxt = '{ST_OK, data_base};
          out_valid_nxt = 1'b1;
        end
      end
      A_REUSE: begin
        if (!out_busy) begin
          in_use_nxt[idx_r[IDX_W-1:0]] = 1'b1;
          out_nxt = '{ST_OK, ent_addr};
          out_valid_nxt = 1'b1;
        end
      end
      A_RFREE: begin
        if (!out_busy) begin
          in_use_nxt[idx_r[IDX_W-1:0]] = 1'b0;
          out_nxt = '{ST_OK, 32'd0};
          out_valid_nxt = 1'b1;
        end
      end
      A_RES_ZERO, A_RES_FULL, A_RES_EXH, A_RES_UNK, A_RES_OK: begin
        if (!out_busy) begin
          case (uw.act)
            A_RES_ZERO: out_nxt = '{ST_ZERO, 32'd0};
            A_RES_FULL: out_nxt = '{ST_FULL, 32'd0};
            A_RES_EXH:  out_nxt = '{ST_EXHAUSTED, 32'd0};
            A_RES_UNK:  out_nxt = '{ST_UNKNOWN, 32'd0};
            default:    out_nxt = '{ST_OK, 32'd0};
          endcase
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // The user must write configuration registers only while the block is idle; the block does not enforce this.
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_HEAP_BASE: begin
          heap_base_nxt = pwdata;
          if (count_r == '0) begin
            heap_top_nxt = pwdata;
          end
        end
        REG_HEAP_LIMIT:   heap_limit_nxt = pwdata;
        REG_HEADER_BYTES: hdr_nxt = pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (paddr[3:2])
      REG_HEAP_BASE:    prdata = heap_base_r;
      REG_HEAP_LIMIT:   prdata = heap_limit_r;
      REG_HEADER_BYTES: prdata = {24'd0, hdr_r};
      default:          prdata = 32'd0;
    endcase
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_WAIT;
      idx_r <= '0;
      count_r <= '0;
      in_use_r <= '0;
      out_valid_r <= 1'b0;
      heap_base_r <= HEAP_BASE_RST;
      heap_limit_r <= HEAP_LIMIT_RST;
      hdr_r <= HEADER_BYTES_RST;
      heap_top_r <= HEAP_BASE_RST;
    end else begin
      upc_r <= upc_nxt;
      idx_r <= idx_nxt;
      count_r <= count_nxt;
      in_use_r <= in_use_nxt;
      out_valid_r <= out_valid_nxt;
      heap_base_r <= heap_base_nxt;
      heap_limit_r <= heap_limit_nxt;
      hdr_r <= hdr_nxt;
      heap_top_r <= heap_top_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    in_r <= in_nxt;
    req_r <= req_nxt;
    out_r <= out_nxt;
  end

  // Block table: data address in the upper half, size in the lower half.
  ffba_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[IDX_W-1:0]),
    .wdata(ram_wdata),
    .raddr(idx_nxt[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_ENTRIES))
    else $error("block count beyond table size");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= count_r)
    else $error("scan index beyond block count");

  a_accept_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (upc_r == S_MUL))
    else $error("accepted word did not enter the multiply step");

  a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == S_NEW && !out_busy) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("new block did not advance the block count");
`endif

endmodule
